// ----- hdl/mva_pkg.sv -----
package mva_pkg;

   // Input event kinds
   localparam logic [2:0] KIND_NOTE_ON    = 3'd0;
   localparam logic [2:0] KIND_NOTE_OFF   = 3'd1;
   localparam logic [2:0] KIND_CHAN_OFF   = 3'd2;
   localparam logic [2:0] KIND_ALL_OFF    = 3'd3;
   localparam logic [2:0] KIND_RHYTHM_OFF = 3'd4;

   // Result actions
   localparam logic [1:0] ACT_KEY_ON  = 2'd0;
   localparam logic [1:0] ACT_KEY_OFF = 2'd1;
   localparam logic [1:0] ACT_DRUM    = 2'd2;

   localparam logic [4:0] DRUM_CHANNEL = 5'd10;
   localparam logic [4:0] MAX_CHANNEL  = 5'd16;

   // Drum key bits
   localparam logic [4:0] DRUM_BASS   = 5'h10;
   localparam logic [4:0] DRUM_SNARE  = 5'h08;
   localparam logic [4:0] DRUM_TOM    = 5'h04;
   localparam logic [4:0] DRUM_CYMBAL = 5'h02;
   localparam logic [4:0] DRUM_HIHAT  = 5'h01;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LEAD,
      ST_REL,
      ST_TRAIL,
      ST_MIN,
      ST_STEAL,
      ST_KEYON
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic plan;
      logic lead_emit;
      logic rel_emit;
      logic trail_emit;
      logic min_step;
      logic steal_emit;
      logic keyon_emit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic plan_lead;
      logic plan_rel;
      logic plan_trail;
      logic plan_noteon;
      logic plan_free;
      logic rel_any;
      logic rel_final;
      logic trail_pend;
      logic min_done;
      logic out_free;
   } dp_status_type;

   // Percussion note to drum key bit, zero when unmapped
   function automatic logic [4:0] drum_bit_of(input logic [6:0] n);
      case (n)
         7'd35, 7'd36: return DRUM_BASS;
         7'd38, 7'd40: return DRUM_SNARE;
         7'd41, 7'd43, 7'd45, 7'd47, 7'd48, 7'd50: return DRUM_TOM;
         7'd42, 7'd44, 7'd46: return DRUM_HIHAT;
         7'd49, 7'd51, 7'd52, 7'd55, 7'd57, 7'd59: return DRUM_CYMBAL;
         default: return 5'd0;
      endcase
   endfunction

endpackage

// ----- hdl/midi_voice_allocator_with_drums_top.sv -----
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  kind, midi_channel, note, velocity
// rsp_      out        rsp_valid / rsp_ready  action, voice, out_note, out_channel,
//                                             out_velocity, drum_mask, drum_trigger,
//                                             rhythm_on, last
//
// One item at a time: the item is accepted, decoded, and then its results are sent in turn.
// A steal adds a scan for the oldest voice, one voice per cycle through a single
// 32-bit age compare, over the voices in use (MELODIC_IN_RHYTHM in rhythm mode).
// Reset is synchronous and clears all voices, the age counter and the drum state.
// A stalled result holds in the output register; the sequencer waits on it.
module midi_voice_allocator_with_drums_top
   import mva_pkg::*;
#(
   parameter int NUM_VOICES        = 9,
   parameter int MELODIC_IN_RHYTHM = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_kind,
   input  logic [4:0] req_midi_channel,
   input  logic [6:0] req_note,
   input  logic [6:0] req_velocity,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_action,
   output logic [3:0] rsp_voice,
   output logic [6:0] rsp_out_note,
   output logic [4:0] rsp_out_channel,
   output logic [6:0] rsp_out_velocity,
   output logic [4:0] rsp_drum_mask,
   output logic [4:0] rsp_drum_trigger,
   output logic       rsp_rhythm_on,
   output logic       rsp_last
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mva_dp #(
      .NUM_VOICES        (NUM_VOICES),
      .MELODIC_IN_RHYTHM (MELODIC_IN_RHYTHM)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_midi_channel (req_midi_channel),
      .req_note         (req_note),
      .req_velocity     (req_velocity),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action       (rsp_action),
      .rsp_voice        (rsp_voice),
      .rsp_out_note     (rsp_out_note),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_out_velocity (rsp_out_velocity),
      .rsp_drum_mask    (rsp_drum_mask),
      .rsp_drum_trigger (rsp_drum_trigger),
      .rsp_rhythm_on    (rsp_rhythm_on),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- hdl/mva_ctrl.sv -----
module mva_ctrl
   import mva_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (status.plan_lead) state_in = ST_LEAD;
            else if (status.plan_rel) state_in = ST_REL;
            else if (status.plan_trail) state_in = ST_TRAIL;
            else if (status.plan_noteon) state_in = status.plan_free ? ST_KEYON : ST_MIN;
            else state_in = ST_IDLE;
         end
         ST_LEAD: begin
            if (status.out_free) begin
               if (status.rel_any) state_in = ST_REL;
               else if (status.trail_pend) state_in = ST_TRAIL;
               else state_in = ST_IDLE;
            end
         end
         ST_REL: begin
            if (status.out_free && status.rel_final)
               state_in = status.trail_pend ? ST_TRAIL : ST_IDLE;
         end
         ST_TRAIL: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_MIN: begin
            if (status.min_done) state_in = ST_STEAL;
         end
         ST_STEAL: begin
            if (status.out_free) state_in = ST_KEYON;
         end
         ST_KEYON: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: cmd.plan       = 1'b1;
         ST_LEAD:   cmd.lead_emit  = status.out_free;
         ST_REL:    cmd.rel_emit   = status.out_free;
         ST_TRAIL:  cmd.trail_emit = status.out_free;
         ST_MIN:    cmd.min_step   = !status.min_done;
         ST_STEAL:  cmd.steal_emit = status.out_free;
         ST_KEYON:  cmd.keyon_emit = status.out_free;
         default:   cmd = '0;
      endcase
   end

endmodule

// ----- hdl/mva_dp.sv -----
module mva_dp
   import mva_pkg::*;
#(
   parameter int NUM_VOICES        = 9,
   parameter int MELODIC_IN_RHYTHM = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic [2:0]    req_kind,
   input  logic [4:0]    req_midi_channel,
   input  logic [6:0]    req_note,
   input  logic [6:0]    req_velocity,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_action,
   output logic [3:0]    rsp_voice,
   output logic [6:0]    rsp_out_note,
   output logic [4:0]    rsp_out_channel,
   output logic [6:0]    rsp_out_velocity,
   output logic [4:0]    rsp_drum_mask,
   output logic [4:0]    rsp_drum_trigger,
   output logic          rsp_rhythm_on,
   output logic          rsp_last
);

   localparam int VW      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CW      = $clog2(NUM_VOICES + 1);
   localparam int MIR_EFF = (MELODIC_IN_RHYTHM > NUM_VOICES) ? NUM_VOICES : MELODIC_IN_RHYTHM;
   localparam logic [CW-1:0] LIM_ALL    = CW'(NUM_VOICES);
   localparam logic [CW-1:0] LIM_RHYTHM = CW'(MIR_EFF);

   // Latched event
   logic [2:0] kind_ff;
   logic [4:0] chan_ff;
   logic [6:0] note_ff, vel_ff;

   // Voice table
   logic [NUM_VOICES-1:0] busy_ff, busy_in;
   logic [6:0]  vnote_ff [NUM_VOICES];
   logic [4:0]  vchan_ff [NUM_VOICES];
   logic [31:0] vage_ff  [NUM_VOICES];
   logic [31:0] age_cnt_ff;

   logic       rhythm_ff, rhythm_in;
   logic [4:0] keys_ff, keys_in;

   // Plan of the current event
   logic [NUM_VOICES-1:0] rel_mask_ff, rel_mask_in;
   logic                  trail_ff;
   logic [6:0]            du_note_ff, du_vel_ff;
   logic [4:0]            du_trig_ff;
   logic [CW-1:0]         lim_ff, scan_ff;
   logic [VW-1:0]         pick_ff;
   logic [31:0]           best_age_ff;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  act_ff;
   logic [3:0]  voice_ff;
   logic [6:0]  onote_ff, ovel_ff;
   logic [4:0]  ochan_ff, otrig_ff;
   logic        last_ff;

   // Event decode
   logic       ch_ok, is_drum_ch, note_off_ev, drum_on_ev, note_on_ev;
   logic       drum_off_ev, mel_off_ev, ch_all_ev, all_off_ev, rdis_ev;
   logic [4:0] dbit;
   logic [NUM_VOICES-1:0] note_m, chan_m, upper_m, free_m, plan_rel_mask;
   logic [CW-1:0] plan_lim;
   logic [VW-1:0] free_pick;
   logic          plan_trail;
   logic [4:0]    plan_keys;
   logic          plan_rhythm;

   assign ch_ok       = (chan_ff != 5'd0) && (chan_ff <= MAX_CHANNEL);
   assign is_drum_ch  = (chan_ff == DRUM_CHANNEL);
   assign dbit        = drum_bit_of(note_ff);
   assign note_off_ev = ch_ok && (((kind_ff == KIND_NOTE_ON) && (vel_ff == 7'd0))
                                  || (kind_ff == KIND_NOTE_OFF));
   assign note_on_ev  = ch_ok && (kind_ff == KIND_NOTE_ON) && (vel_ff != 7'd0) && !is_drum_ch;
   assign drum_on_ev  = ch_ok && (kind_ff == KIND_NOTE_ON) && (vel_ff != 7'd0) && is_drum_ch
                        && (dbit != 5'd0);
   assign drum_off_ev = note_off_ev && is_drum_ch && (dbit != 5'd0);
   assign mel_off_ev  = note_off_ev && !is_drum_ch;
   assign ch_all_ev   = ch_ok && (kind_ff == KIND_CHAN_OFF);
   assign all_off_ev  = (kind_ff == KIND_ALL_OFF);
   assign rdis_ev     = (kind_ff == KIND_RHYTHM_OFF) && rhythm_ff;
   assign plan_lim    = rhythm_ff ? LIM_RHYTHM : LIM_ALL;

   // Per-voice match lanes
   always_comb begin
      for (int v = 0; v < NUM_VOICES; v++) begin
         note_m[v]  = busy_ff[v] && (vnote_ff[v] == note_ff) && (vchan_ff[v] == chan_ff);
         chan_m[v]  = busy_ff[v] && (vchan_ff[v] == chan_ff);
         upper_m[v] = (v >= MIR_EFF);
         free_m[v]  = !busy_ff[v] && (CW'(v) < plan_lim);
      end
   end

   // Lowest free voice
   always_comb begin
      free_pick = '0;
      for (int v = NUM_VOICES - 1; v >= 0; v--) begin
         if (free_m[v]) free_pick = VW'(v);
      end
   end

   // Release set, trailing drum update and final drum state
   always_comb begin
      plan_rel_mask = '0;
      if (mel_off_ev) plan_rel_mask = note_m;
      else if (ch_all_ev) plan_rel_mask = chan_m;
      else if (all_off_ev) plan_rel_mask = busy_ff;
      else if (drum_on_ev && !rhythm_ff) plan_rel_mask = busy_ff & upper_m;

      plan_trail = drum_on_ev || (drum_off_ev && rhythm_ff) || (all_off_ev && rhythm_ff)
                   || rdis_ev;

      plan_keys   = keys_ff;
      plan_rhythm = rhythm_ff;
      if (drum_on_ev) begin
         plan_keys   = (rhythm_ff ? keys_ff : 5'd0) | dbit;
         plan_rhythm = 1'b1;
      end else if (drum_off_ev) begin
         plan_keys = keys_ff & ~dbit;
      end else if ((ch_all_ev && is_drum_ch) || all_off_ev) begin
         plan_keys = 5'd0;
      end else if (rdis_ev) begin
         plan_keys   = 5'd0;
         plan_rhythm = 1'b0;
      end
   end

   // Release walk: lowest pending voice first
   logic [NUM_VOICES-1:0] rel_oh, rel_rest;
   logic [VW-1:0]         rel_ix;

   assign rel_oh   = rel_mask_ff & (~rel_mask_ff + NUM_VOICES'(1));
   assign rel_rest = rel_mask_ff & ~rel_oh;

   always_comb begin
      rel_ix = '0;
      for (int v = 0; v < NUM_VOICES; v++) begin
         if (rel_oh[v]) rel_ix = VW'(v);
      end
   end

   // Oldest-voice scan, one voice per cycle
   logic          min_done;
   logic [VW-1:0] scan_ix;
   logic [31:0]   scan_age;
   logic          scan_older;

   assign min_done   = (scan_ff >= lim_ff);
   assign scan_ix    = min_done ? '0 : scan_ff[VW-1:0];
   assign scan_age   = vage_ff[scan_ix];
   assign scan_older = (scan_age < best_age_ff);

   assign status.plan_lead   = ch_all_ev && is_drum_ch;
   assign status.plan_rel    = (plan_rel_mask != '0);
   assign status.plan_trail  = plan_trail;
   assign status.plan_noteon = note_on_ev;
   assign status.plan_free   = (free_m != '0);
   assign status.rel_any     = (rel_mask_ff != '0);
   assign status.rel_final   = (rel_rest == '0);
   assign status.trail_pend  = trail_ff;
   assign status.min_done    = min_done;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   // Event capture and plan registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         chan_ff <= req_midi_channel;
         note_ff <= req_note;
         vel_ff  <= req_velocity;
      end
      if (cmd.plan) begin
         trail_ff    <= plan_trail;
         du_note_ff  <= (drum_on_ev || drum_off_ev) ? note_ff : 7'd0;
         du_vel_ff   <= drum_on_ev ? vel_ff : 7'd0;
         du_trig_ff  <= drum_on_ev ? dbit : 5'd0;
         lim_ff      <= plan_lim;
         scan_ff     <= CW'(1);
         pick_ff     <= free_pick;
         best_age_ff <= vage_ff[0];
      end else if (cmd.min_step) begin
         scan_ff <= scan_ff + CW'(1);
         if (scan_older) begin
            best_age_ff <= scan_age;
            pick_ff     <= scan_ix;
         end
      end
   end

   // Voice payload written on key on
   always_ff @(posedge clock) begin
      if (cmd.keyon_emit) begin
         vnote_ff[pick_ff] <= note_ff;
         vchan_ff[pick_ff] <= chan_ff;
         vage_ff[pick_ff]  <= age_cnt_ff + 32'd1;
      end
   end

   // Control state next values
   always_comb begin
      busy_in     = busy_ff;
      rel_mask_in = rel_mask_ff;
      keys_in     = keys_ff;
      rhythm_in   = rhythm_ff;
      if (cmd.plan) begin
         rel_mask_in = plan_rel_mask;
         keys_in     = plan_keys;
         rhythm_in   = plan_rhythm;
      end
      if (cmd.rel_emit) begin
         busy_in     = busy_ff & ~rel_oh;
         rel_mask_in = rel_rest;
      end
      if (cmd.keyon_emit) busy_in[pick_ff] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= '0;
         rel_mask_ff <= '0;
         age_cnt_ff  <= '0;
         rhythm_ff   <= 1'b0;
         keys_ff     <= '0;
      end else begin
         busy_ff     <= busy_in;
         rel_mask_ff <= rel_mask_in;
         rhythm_ff   <= rhythm_in;
         keys_ff     <= keys_in;
         if (cmd.keyon_emit) age_cnt_ff <= age_cnt_ff + 32'd1;
      end
   end

   // Result register
   assign rsp_valid_in = (cmd.lead_emit || cmd.rel_emit || cmd.trail_emit ||
                          cmd.steal_emit || cmd.keyon_emit) ||
                         (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lead_emit || cmd.trail_emit) begin
         act_ff   <= ACT_DRUM;
         voice_ff <= 4'd0;
         onote_ff <= du_note_ff;
         ochan_ff <= DRUM_CHANNEL;
         ovel_ff  <= du_vel_ff;
         otrig_ff <= du_trig_ff;
         last_ff  <= cmd.trail_emit || (!status.rel_any && !trail_ff);
      end else if (cmd.rel_emit) begin
         act_ff   <= ACT_KEY_OFF;
         voice_ff <= 4'(rel_ix);
         onote_ff <= vnote_ff[rel_ix];
         ochan_ff <= vchan_ff[rel_ix];
         ovel_ff  <= 7'd0;
         otrig_ff <= 5'd0;
         last_ff  <= status.rel_final && !trail_ff;
      end else if (cmd.steal_emit) begin
         act_ff   <= ACT_KEY_OFF;
         voice_ff <= 4'(pick_ff);
         onote_ff <= vnote_ff[pick_ff];
         ochan_ff <= vchan_ff[pick_ff];
         ovel_ff  <= 7'd0;
         otrig_ff <= 5'd0;
         last_ff  <= 1'b0;
      end else if (cmd.keyon_emit) begin
         act_ff   <= ACT_KEY_ON;
         voice_ff <= 4'(pick_ff);
         onote_ff <= note_ff;
         ochan_ff <= chan_ff;
         ovel_ff  <= vel_ff;
         otrig_ff <= 5'd0;
         last_ff  <= 1'b1;
      end
   end

   // Drum state is final once the plan is taken, so every result shows it
   logic [4:0] omask_ff;
   logic       orhy_ff;

   always_ff @(posedge clock) begin
      if (cmd.lead_emit || cmd.rel_emit || cmd.trail_emit || cmd.steal_emit ||
          cmd.keyon_emit) begin
         omask_ff <= keys_ff;
         orhy_ff  <= rhythm_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = act_ff;
   assign rsp_voice        = voice_ff;
   assign rsp_out_note     = onote_ff;
   assign rsp_out_channel  = ochan_ff;
   assign rsp_out_velocity = ovel_ff;
   assign rsp_drum_mask    = omask_ff;
   assign rsp_drum_trigger = otrig_ff;
   assign rsp_rhythm_on    = orhy_ff;
   assign rsp_last         = last_ff;

endmodule

// ----- hdl/mva_checker.sv -----
module mva_checker
   import mva_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_action,
   input logic [3:0] rsp_voice,
   input logic [6:0] rsp_out_note,
   input logic [4:0] rsp_out_channel,
   input logic [6:0] rsp_out_velocity,
   input logic [4:0] rsp_drum_mask,
   input logic [4:0] rsp_drum_trigger,
   input logic       rsp_rhythm_on,
   input logic       rsp_last
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) && $stable(rsp_voice)
         && $stable(rsp_out_note) && $stable(rsp_last))
      else $error("result changed while stalled");

   // One item in flight: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   // Drum updates carry voice zero on the drum channel
   a_drum_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_DRUM) |-> (rsp_voice == 4'd0)
         && (rsp_out_channel == DRUM_CHANNEL))
      else $error("bad drum update fields");

   // A key on always closes its item and has a velocity
   a_keyon_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_KEY_ON) |-> rsp_last && (rsp_out_velocity != 7'd0))
      else $error("key on not final or silent");

   // A retriggered drum is set in the mask with rhythm mode on
   a_trig_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_drum_trigger != 5'd0) |-> rsp_rhythm_on
         && ((rsp_drum_mask & rsp_drum_trigger) == rsp_drum_trigger))
      else $error("drum trigger not in mask");

endmodule

bind midi_voice_allocator_with_drums_top mva_checker u_mva_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_action       (rsp_action),
   .rsp_voice        (rsp_voice),
   .rsp_out_note     (rsp_out_note),
   .rsp_out_channel  (rsp_out_channel),
   .rsp_out_velocity (rsp_out_velocity),
   .rsp_drum_mask    (rsp_drum_mask),
   .rsp_drum_trigger (rsp_drum_trigger),
   .rsp_rhythm_on    (rsp_rhythm_on),
   .rsp_last         (rsp_last)
);
